FILE: hdl/dutr_pkg.sv
// ----------------------------------------------------------------------------
// dutr_pkg
// Shared types and codes of the dual UART / timer register model: command
// kinds, register addresses, interrupt bit positions and the packed layouts
// of one input transfer and one result transfer.
// ----------------------------------------------------------------------------
package dutr_pkg;

    // Stream widths (tdata in whole bytes)
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 40;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_RXBYTE = 2'd3
    } t_command;

    // Register addresses (bit 3 selects the channel where it applies)
    localparam logic [3:0] ADR_MR_A     = 4'd0;
    localparam logic [3:0] ADR_SR_A     = 4'd1;
    localparam logic [3:0] ADR_CR_A     = 4'd2;
    localparam logic [3:0] ADR_HR_A     = 4'd3;
    localparam logic [3:0] ADR_ISR      = 4'd5;
    localparam logic [3:0] ADR_CT_HI    = 4'd6;
    localparam logic [3:0] ADR_CT_LO    = 4'd7;
    localparam logic [3:0] ADR_MR_B     = 4'd8;
    localparam logic [3:0] ADR_SR_B     = 4'd9;
    localparam logic [3:0] ADR_CR_B     = 4'd10;
    localparam logic [3:0] ADR_HR_B     = 4'd11;
    localparam logic [3:0] ADR_OPCR     = 4'd13;
    localparam logic [3:0] ADR_SET_OP   = 4'd14;
    localparam logic [3:0] ADR_CLR_OP   = 4'd15;

    // Command register sub-commands (bits 6..4)
    localparam logic [2:0] SUBCMD_RESET_MR = 3'd1;
    localparam logic [2:0] SUBCMD_RESET_TX = 3'd3;
    localparam logic [2:0] SUBCMD_RESET_MP = 3'd4;

    // Interrupt level positions
    localparam logic [2:0] IRQ_MRX = 3'd0;
    localparam logic [2:0] IRQ_MTX = 3'd1;
    localparam logic [2:0] IRQ_DRX = 3'd2;
    localparam logic [2:0] IRQ_DTX = 3'd3;
    localparam logic [2:0] IRQ_TMR = 3'd4;

    // Status bits
    localparam logic [1:0] STAT_RXRDY = 2'd0;
    localparam logic [1:0] STAT_TXRDY = 2'd2;

    // Mode register slot of channel B's first mode register
    localparam logic [1:0] MR_IDX_B1 = 2'd2;

    // Output port bits with a special use
    localparam logic [2:0] OP_LOOP_B  = 3'd2;
    localparam logic [2:0] OP_TIMER   = 3'd3;
    localparam logic [2:0] OP_IRQ_MRX = 3'd4;
    localparam logic [2:0] OP_IRQ_DRX = 3'd5;
    localparam logic [2:0] OP_IRQ_DTX = 3'd7;

    typedef enum logic [2:0] {
        TP_STOPPED  = 3'b001,
        TP_ARMED    = 3'b010,
        TP_COUNTING = 3'b100
    } t_timer_phase;

    // One input item, lowest field last in the list
    typedef struct packed {
        logic       channel;
        logic [7:0] data;
        logic [3:0] address;
    } t_in_item;

    // One result item, lowest field last in the list
    typedef struct packed {
        logic [7:0] output_port;
        logic       irq_timer;
        logic       irq_diag_tx;
        logic       irq_diag_rx;
        logic       irq_modem_tx;
        logic       irq_modem_rx;
        logic       rx_accepted;
        logic       tx_address_flag;
        logic [7:0] tx_byte;
        logic       tx_channel;
        logic       tx_valid;
        logic [7:0] read_data;
    } t_result;

    localparam int unsigned IN_PAD_W  = IN_TDATA_W - $bits(t_in_item);
    localparam int unsigned OUT_PAD_W = OUT_TDATA_W - $bits(t_result);

endpackage

FILE: hdl/dual_uart_timer_register_model.sv
// ----------------------------------------------------------------------------
// dual_uart_timer_register_model
// Register model of a two-channel UART with a 16-bit counter/timer: bus
// reads and writes, timer ticks and received bytes, one result per item.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+---------
//  s (item) | in  | address[3:0] data[11:4] channel[12] pad    | command
//  m (res)  | out | read_data[7:0] tx_valid[8] tx_channel[9]   | -
//           |     | tx_byte[17:10] tx_address_flag[18]         |
//           |     | rx_accepted[19] irq mrx,mtx,drx,dtx,tmr    |
//           |     | [24:20] output_port[32:25] pad             |
//
//  One item per cycle while results drain; the input register feeds the result
//  register, with the whole register update done in one pass.
//  Synchronous active-low reset clears all model state, timer stopped.
//  A stalled result holds in the result register while one more item is
//  taken into the input register; the input side stalls only then.
// ----------------------------------------------------------------------------
module dual_uart_timer_register_model (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // address, data, channel, zero pad
    input  logic [dutr_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // command
    input  logic [dutr_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // read_data, tx_valid, tx_channel, tx_byte, tx_address_flag,
    // rx_accepted, irq_modem_rx, irq_modem_tx, irq_diag_rx, irq_diag_tx,
    // irq_timer, output_port, zero pad
    output logic [dutr_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import dutr_pkg::*;

    // Input stage
    logic         r_in_valid;
    t_in_item     r_in_item;
    t_command     r_in_cmd;

    // Result stage
    logic         r_out_valid;
    t_result      r_res;
    t_result      n_res;

    // Model state
    logic [7:0]   r_mode   [4];
    logic         r_ptr    [2];
    logic [2:0]   r_status [2];
    logic [7:0]   r_hold   [2];
    logic         r_rx_en  [2];
    logic         r_tx_en  [2];
    logic [15:0]  r_preload;
    logic [15:0]  r_count;
    t_timer_phase r_phase;
    logic         r_tmr_en;
    logic         r_zflag;
    logic [7:0]   r_port;
    logic [4:0]   r_irq;

    logic [7:0]   n_mode   [4];
    logic         n_ptr    [2];
    logic [2:0]   n_status [2];
    logic [7:0]   n_hold   [2];
    logic         n_rx_en  [2];
    logic         n_tx_en  [2];
    logic [15:0]  n_preload;
    logic [15:0]  n_count;
    t_timer_phase n_phase;
    logic         n_tmr_en;
    logic         n_zflag;
    logic [7:0]   n_port;
    logic [4:0]   n_irq;

    logic         w_advance;

    // Move the held item on whenever the result register is free or drains.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_in_item <= t_in_item'(i_s_tdata[$bits(t_in_item)-1:0]);
            r_in_cmd  <= t_command'(i_s_tuser);
        end
    end

    // Single-pass register update for the item in the input register.
    always_comb begin
        logic       ch;
        logic [7:0] d;
        logic [2:0] sub;
        logic [2:0] rx_irq;
        logic [2:0] tx_irq;

        ch     = r_in_item.address[3];
        d      = r_in_item.data;
        sub    = d[6:4];
        rx_irq = ch ? IRQ_DRX : IRQ_MRX;
        tx_irq = ch ? IRQ_DTX : IRQ_MTX;

        n_mode    = r_mode;
        n_ptr     = r_ptr;
        n_status  = r_status;
        n_hold    = r_hold;
        n_rx_en   = r_rx_en;
        n_tx_en   = r_tx_en;
        n_preload = r_preload;
        n_count   = r_count;
        n_phase   = r_phase;
        n_tmr_en  = r_tmr_en;
        n_zflag   = r_zflag;
        n_port    = r_port;
        n_irq     = r_irq;
        n_res     = '0;

        case (r_in_cmd)
            CMD_READ: begin
                case (r_in_item.address)
                    ADR_SR_A, ADR_SR_B: begin
                        n_res.read_data = {5'd0, r_status[ch]};
                    end
                    ADR_HR_A, ADR_HR_B: begin
                        // Reading the holding byte clears receive ready.
                        n_status[ch][STAT_RXRDY] = 1'b0;
                        n_irq[rx_irq]            = 1'b0;
                        n_res.read_data          = r_hold[ch];
                    end
                    ADR_ISR: begin
                        n_res.read_data = {4'd0, r_zflag, 3'd0};
                    end
                    ADR_CT_HI: begin
                        n_res.read_data = r_count[15:8];
                    end
                    ADR_CT_LO: begin
                        n_res.read_data = r_count[7:0];
                    end
                    ADR_SET_OP: begin
                        // Start: reload the count and arm for the next tick.
                        n_count = r_preload;
                        n_phase = TP_ARMED;
                    end
                    ADR_CLR_OP: begin
                        // Stop: halt the timer and drop its interrupt.
                        n_phase        = TP_STOPPED;
                        n_zflag        = 1'b0;
                        n_irq[IRQ_TMR] = 1'b0;
                        if (r_tmr_en) begin
                            n_port[OP_TIMER] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_WRITE: begin
                case (r_in_item.address)
                    ADR_MR_A, ADR_MR_B: begin
                        n_mode[{ch, r_ptr[ch]}] = d;
                        n_ptr[ch]               = ~r_ptr[ch];
                    end
                    ADR_CR_A, ADR_CR_B: begin
                        if (sub == SUBCMD_RESET_MR || sub == SUBCMD_RESET_MP) begin
                            n_ptr[ch] = 1'b0;
                        end
                        if (sub == SUBCMD_RESET_TX) begin
                            n_tx_en[ch]              = 1'b0;
                            n_status[ch][STAT_TXRDY] = 1'b0;
                            n_irq[tx_irq]            = 1'b0;
                        end
                        if (d[0]) begin
                            n_rx_en[ch] = 1'b1;
                        end
                        if (d[1]) begin
                            n_rx_en[ch] = 1'b0;
                        end
                        if (d[2]) begin
                            n_tx_en[ch]              = 1'b1;
                            n_status[ch][STAT_TXRDY] = 1'b1;
                            n_irq[tx_irq]            = 1'b1;
                        end
                        if (d[3]) begin
                            n_tx_en[ch]              = 1'b0;
                            n_status[ch][STAT_TXRDY] = 1'b0;
                            n_irq[tx_irq]            = 1'b0;
                        end
                    end
                    ADR_HR_A, ADR_HR_B: begin
                        // Loopback stores the byte as received, no interrupt.
                        if ((ch && r_port[OP_LOOP_B]) || r_mode[{ch, 1'b1}][7]) begin
                            n_hold[ch]               = d;
                            n_status[ch][STAT_RXRDY] = 1'b1;
                        end else begin
                            n_res.tx_valid        = 1'b1;
                            n_res.tx_channel      = ch;
                            n_res.tx_byte         = d;
                            n_res.tx_address_flag = ch & r_mode[MR_IDX_B1][2];
                        end
                    end
                    ADR_CT_HI: begin
                        n_preload[15:8] = d;
                    end
                    ADR_CT_LO: begin
                        n_preload[7:0] = d;
                    end
                    ADR_OPCR: begin
                        n_tmr_en = (d[3:2] == 2'b01);
                    end
                    ADR_SET_OP: begin
                        n_port = r_port | d;
                        if (n_port[OP_IRQ_MRX]) n_irq[IRQ_MRX] = 1'b1;
                        if (n_port[OP_IRQ_DRX]) n_irq[IRQ_DRX] = 1'b1;
                        if (n_port[OP_IRQ_DTX]) n_irq[IRQ_DTX] = 1'b1;
                    end
                    ADR_CLR_OP: begin
                        n_port = r_port & ~d;
                        if (!n_port[OP_IRQ_MRX]) n_irq[IRQ_MRX] = 1'b0;
                        if (!n_port[OP_IRQ_DRX]) n_irq[IRQ_DRX] = 1'b0;
                        if (!n_port[OP_IRQ_DTX]) n_irq[IRQ_DTX] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_TICK: begin
                case (r_phase)
                    TP_ARMED: begin
                        n_phase = TP_COUNTING;
                    end
                    TP_COUNTING: begin
                        n_count = r_count - 16'd1;
                        if (n_count == 16'd0) begin
                            n_zflag = 1'b1;
                            if (r_tmr_en) begin
                                n_irq[IRQ_TMR]   = 1'b1;
                                n_port[OP_TIMER] = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // Received byte: refuse it while the receiver is off or full.
                if (r_rx_en[r_in_item.channel] &&
                    !r_status[r_in_item.channel][STAT_RXRDY]) begin
                    n_hold[r_in_item.channel]               = d;
                    n_status[r_in_item.channel][STAT_RXRDY] = 1'b1;
                    n_irq[r_in_item.channel ? IRQ_DRX : IRQ_MRX] = 1'b1;
                    n_res.rx_accepted = 1'b1;
                end
            end
        endcase

        n_res.irq_modem_rx = n_irq[IRQ_MRX];
        n_res.irq_modem_tx = n_irq[IRQ_MTX];
        n_res.irq_diag_rx  = n_irq[IRQ_DRX];
        n_res.irq_diag_tx  = n_irq[IRQ_DTX];
        n_res.irq_timer    = n_irq[IRQ_TMR];
        n_res.output_port  = n_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= '{default: 8'd0};
            r_ptr       <= '{default: 1'b0};
            r_status    <= '{default: 3'd0};
            r_hold      <= '{default: 8'd0};
            r_rx_en     <= '{default: 1'b0};
            r_tx_en     <= '{default: 1'b0};
            r_preload   <= 16'd0;
            r_count     <= 16'd0;
            r_phase     <= TP_STOPPED;
            r_tmr_en    <= 1'b0;
            r_zflag     <= 1'b0;
            r_port      <= 8'd0;
            r_irq       <= 5'd0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_ptr       <= n_ptr;
                r_status    <= n_status;
                r_hold      <= n_hold;
                r_rx_en     <= n_rx_en;
                r_tx_en     <= n_tx_en;
                r_preload   <= n_preload;
                r_count     <= n_count;
                r_phase     <= n_phase;
                r_tmr_en    <= n_tmr_en;
                r_zflag     <= n_zflag;
                r_port      <= n_port;
                r_irq       <= n_irq;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_res <= n_res;
        end
    end

endmodule

FILE: hdl/dutr_checker.sv
// ----------------------------------------------------------------------------
// dutr_checker
// Port-level checks of the dual UART / timer register model, bound to the
// top level.
// ----------------------------------------------------------------------------
module dutr_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [dutr_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import dutr_pkg::*;

    t_result w_res;
    assign w_res = t_result'(o_m_tdata[$bits(t_result)-1:0]);

    // Hold a stalled result transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result transfer changed while stalled");

    // The input side stalls only behind a stalled result.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output back-pressure");

    a_tx_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_res.tx_valid |->
            !w_res.tx_channel && w_res.tx_byte == 8'd0 && !w_res.tx_address_flag)
        else $error("transmit fields set without a transmit");

    a_addr_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_res.tx_address_flag |-> w_res.tx_valid && w_res.tx_channel)
        else $error("address flag outside a diagnostic transmit");

    // One kind of item per result: read data, transmit and receive exclude.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(w_res.tx_valid && w_res.rx_accepted) &&
            !((w_res.read_data != 8'd0) && (w_res.tx_valid || w_res.rx_accepted)))
        else $error("result mixes read, transmit and receive");

endmodule

bind dual_uart_timer_register_model dutr_checker u_dutr_checker (.*);
